### rtl/wheel_crank_speed_cadence_core_assert.svh
// ----------------------------------------------------------------------------
// Wheel/crank speed and cadence core: assertion macros
// Concurrent checks on clk, WCCS_ASSERT masked during reset; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WHEEL_CRANK_SPEED_CADENCE_CORE_ASSERT_SVH
`define WHEEL_CRANK_SPEED_CADENCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WCCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wccs check failed");
`define WCCS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wccs check failed");
`else
`define WCCS_ASSERT(label, prop)
`define WCCS_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/wccs_pkg.sv
// ----------------------------------------------------------------------------
// wccs_pkg
// Shared types and constants of the speed/cadence core.
// ----------------------------------------------------------------------------
`default_nettype none
package wccs_pkg;

  localparam logic [12:0] CIRC_RESET    = 13'd2100;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam int          DEN_W         = 24;

  // One unit of work for the back part
  typedef struct packed {
    logic        timeout;   // zero result from the stop countdown
    logic        cad_ok;
    logic        cad_div;   // cadence needs a division
    logic [15:0] crank_dr;
    logic [15:0] crank_dt;
    logic        spd_ok;
    logic        spd_div;   // speed needs a division
    logic [31:0] wheel_dr;
    logic [15:0] wheel_dt;
    logic [12:0] circ;
  } wccs_job_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CDIV  = 6'b000010,
    S_MUL   = 6'b000100,
    S_SCALE = 6'b001000,
    S_SDIV  = 6'b010000,
    S_DONE  = 6'b100000
  } wccs_state_t;

endpackage
`default_nettype wire

### rtl/wccs_front.sv
// ----------------------------------------------------------------------------
// wccs_front
// Accepts items, checks length, keeps last values and the stop countdown,
// and issues jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module wccs_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  mode,
  input  wire  [7:0]           byte_count,
  input  wire  [7:0]           flags,
  input  wire  [31:0]          wheel_revs,
  input  wire  [15:0]          wheel_time,
  input  wire  [15:0]          crank_revs,
  input  wire  [15:0]          crank_time,
  input  wire  [12:0]          circ,
  input  wire  [15:0]          timeout_ticks,
  input  wire                  q_full,
  output logic                 push,
  output wccs_pkg::wccs_job_t  job
);
  import wccs_pkg::*;

  logic        awaiting_first;
  logic [31:0] last_wheel_count;
  logic [15:0] last_wheel_stamp;
  logic [15:0] last_crank_count;
  logic [15:0] last_crank_stamp;
  logic [15:0] stop_countdown;

  logic        fire, wheel, crank, len_ok;
  logic [3:0]  need;
  logic [31:0] ws;
  logic [15:0] wt, cs, ct, cdt, cdr, wdt;
  logic [31:0] wdr;
  logic [15:0] cd_dec;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Classify the item
  always_comb begin
    wheel  = flags[0];
    crank  = flags[1];
    need   = 4'd1 + (wheel ? 4'd6 : 4'd0) + (crank ? 4'd4 : 4'd0);
    len_ok = (byte_count != 8'd0) && (byte_count >= {4'd0, need});
    ws     = wheel ? wheel_revs : 32'd0;
    wt     = wheel ? wheel_time : 16'd0;
    cs     = crank ? crank_revs : 16'd0;
    ct     = crank ? crank_time : 16'd0;
    cdt    = ct - last_crank_stamp;
    cdr    = cs - last_crank_count;
    wdt    = wt - last_wheel_stamp;
    wdr    = ws - last_wheel_count;
    cd_dec = stop_countdown - 16'd1;

    job          = '0;
    job.crank_dr = cdr;
    job.crank_dt = cdt;
    job.wheel_dr = wdr;
    job.wheel_dt = wdt;
    job.circ     = circ;
    push         = 1'b0;
    if (mode) begin
      job.timeout = 1'b1;
      push = fire && (stop_countdown != 16'd0) && (cd_dec == 16'd0);
    end else begin
      job.cad_div = crank && (cdt != 16'd0);
      job.cad_ok  = crank && ((cdt != 16'd0) || (cdr == 16'd0));
      job.spd_div = wheel && (wdt != 16'd0);
      job.spd_ok  = wheel && ((wdt != 16'd0) || (wdr == 32'd0));
      push = fire && len_ok && !awaiting_first && (job.cad_ok || job.spd_ok);
    end
  end

  // Update last values and countdown
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first   <= 1'b1;
      last_wheel_count <= '0;
      last_wheel_stamp <= '0;
      last_crank_count <= '0;
      last_crank_stamp <= '0;
      stop_countdown   <= '0;
    end else if (fire) begin
      if (mode) begin
        if (stop_countdown != 16'd0) stop_countdown <= cd_dec;
      end else if (len_ok) begin
        if (awaiting_first) begin
          awaiting_first   <= 1'b0;
          last_wheel_count <= ws;
          last_wheel_stamp <= wt;
          last_crank_count <= cs;
          last_crank_stamp <= ct;
        end else begin
          if (crank) begin
            last_crank_count <= cs;
            last_crank_stamp <= ct;
          end
          if (wheel) begin
            last_wheel_count <= ws;
            last_wheel_stamp <= wt;
          end
          stop_countdown <= timeout_ticks;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/wccs_queue.sv
// ----------------------------------------------------------------------------
// wccs_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module wccs_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wccs_pkg::wccs_job_t  push_job,
  output logic                 full,
  input  wire                  pop,
  output logic                 not_empty,
  output wccs_pkg::wccs_job_t  head
);
  import wccs_pkg::*;

  wccs_job_t  mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/wccs_back.sv
// ----------------------------------------------------------------------------
// wccs_back
// Carries out jobs: shared restoring divider for cadence then speed,
// saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wheel_crank_speed_cadence_core_assert.svh"
module wccs_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_not_empty,
  input  wccs_pkg::wccs_job_t  q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 o_cadence_valid,
  output logic [30:0]          o_cadence_rpm,
  output logic                 o_speed_valid,
  output logic [31:0]          o_speed_centi_kmh,
  output logic                 o_timed_out
);
  import wccs_pkg::*;

  wccs_state_t state;
  wccs_job_t   cur;
  logic [63:0] dvd, quo;
  logic [DEN_W-1:0] rem, den;
  logic [5:0]  cnt;
  logic [44:0] prod;
  logic [30:0] cad;
  logic [31:0] spd;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [63:0]      quo_next;
  logic [31:0]      cad_num;
  logic [48:0]      prod9;
  logic [22:0]      spd_den;
  logic             load_out;

  // Divider step and operand shaping
  always_comb begin
    trial    = {rem, dvd[63]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    quo_next = {quo[62:0], ge};
    cad_num  = {q_head.crank_dr, 16'd0} - {4'd0, q_head.crank_dr, 12'd0};
    prod9    = {1'b0, prod, 3'd0} + {4'd0, prod};
    spd_den  = {1'b0, cur.wheel_dt, 6'd0} + {2'd0, cur.wheel_dt, 5'd0}
             + {5'd0, cur.wheel_dt, 2'd0};
  end

  assign pop      = (state == S_IDLE) && q_not_empty;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // Sequence one job
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            cur <= q_head;
            cad <= '0;
            spd <= '0;
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            dvd <= {32'd0, cad_num};
            den <= {8'd0, q_head.crank_dt};
            if (q_head.timeout) state <= S_DONE;
            else if (q_head.cad_div) state <= S_CDIV;
            else state <= S_MUL;
          end
        end
        S_CDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          dvd <= {dvd[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cad   <= (quo_next[63:31] != '0) ? 31'h7FFF_FFFF : quo_next[30:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 45'(cur.circ * cur.wheel_dr);
          state <= S_SCALE;
        end
        S_SCALE: begin
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          dvd <= {3'd0, prod9, 12'd0};
          den <= {1'b0, spd_den};
          state <= cur.spd_div ? S_SDIV : S_DONE;
        end
        S_SDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          dvd <= {dvd[62:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            spd   <= (quo_next[63:32] != '0) ? 32'hFFFF_FFFF : quo_next[31:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            o_timed_out       <= cur.timeout;
            o_cadence_valid   <= cur.timeout || cur.cad_ok;
            o_speed_valid     <= cur.timeout || cur.spd_ok;
            o_cadence_rpm     <= cur.timeout ? '0 : cad;
            o_speed_centi_kmh <= cur.timeout ? '0 : spd;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WCCS_ASSERT(a_pop_only_idle, pop |-> (state == S_IDLE))
  `WCCS_ASSERT(a_done_loads, ((state == S_DONE) && !out_valid) |=> out_valid)
  `WCCS_ASSERT(a_timeout_zero,
    (out_valid && o_timed_out) |-> (o_cadence_rpm == '0 && o_speed_centi_kmh == '0))

endmodule
`default_nettype wire

### rtl/wheel_crank_speed_cadence_core.sv
// Wheel/crank speed and cadence core.
// Input stream s_*: one beat is a measurement (s_tuser = 0) or one time tick
// (s_tuser = 1). Output stream m_*: at most one result beat per input beat.
// APB port: register 0 (addr 0) wheel circumference in mm, register 1
// (addr 4) stop timeout in ticks; write only while the core is idle.
// A measurement with both values runs two 64-step divisions on the shared
// divider before m_tvalid rises; a timeout result skips the divider. The
// back takes one job at a time and pops the next only when idle. Items that
// yield no result are accepted by the front and push no job.
// A two-entry job queue lets the front accept while the back computes; the
// front stalls s_tready only when that queue is full. A stalled receiver
// holds the result register, and the back waits in its final step.
// Reset clears all last values, the countdown and the queue, and restores
// the register defaults.
// ----------------------------------------------------------------------------
// wheel_crank_speed_cadence_core
// Top level: stream ports, config registers, front, queue and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module wheel_crank_speed_cadence_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // byte_count[7:0], flags[15:8], wheel_revs[47:16], wheel_time[63:48],
  // crank_revs[79:64], crank_time[95:80]
  input  wire  [95:0] s_tdata,
  // mode[0]
  input  wire         s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // cadence_valid[0], cadence_rpm[31:1], speed_valid[32],
  // speed_centi_kmh[64:33], timed_out[65], zero[71:66]
  output logic [71:0] m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wccs_pkg::*;

  logic [12:0] circ;
  logic [15:0] timeout_ticks;
  logic        cfg_wr;

  wccs_job_t push_job, head;
  logic      push, full, pop, not_empty;

  logic        cad_v, spd_v, tmo;
  logic [30:0] cad;
  logic [31:0] spd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {16'd0, timeout_ticks} : {19'd0, circ};

  // Hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      circ          <= CIRC_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) timeout_ticks <= pwdata[15:0];
      else          circ          <= pwdata[12:0];
    end
  end

  wccs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .mode(s_tuser), .byte_count(s_tdata[7:0]), .flags(s_tdata[15:8]),
    .wheel_revs(s_tdata[47:16]), .wheel_time(s_tdata[63:48]),
    .crank_revs(s_tdata[79:64]), .crank_time(s_tdata[95:80]),
    .circ(circ), .timeout_ticks(timeout_ticks),
    .q_full(full), .push(push), .job(push_job)
  );

  wccs_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_job(push_job), .full(full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  wccs_back u_back (
    .clk(clk), .rst(rst),
    .q_not_empty(not_empty), .q_head(head), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .o_cadence_valid(cad_v), .o_cadence_rpm(cad),
    .o_speed_valid(spd_v), .o_speed_centi_kmh(spd), .o_timed_out(tmo)
  );

  assign m_tdata = {6'd0, tmo, spd, spd_v, cad, cad_v};

endmodule
`default_nettype wire
